// File: rtl/plu_pkg.sv
// plu_pkg: shared widths, factorial table and cell control type for the
// permutation unranking block. No dependencies.
package plu_pkg;

  localparam int RANK_W           = 45;  // lexicographic rank width
  localparam int VAL_W            = 4;   // element value and position width
  localparam int SIZE_W           = 5;   // perm_size register width
  localparam int RESULT_LIMIT     = 16;  // most elements a permutation can have
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int QBITS            = 4;   // quotient bits per factorial digit
  localparam int DIV_W            = RANK_W + QBITS - 1;

  // control handed to every cell of the chain
  typedef struct packed {
    logic load;  // capture a fresh digit
    logic step;  // one compare-and-bump step with the shifted original digit
  } cell_ctrl_t;

  // i! for i = 0..16, 16! still fits the rank width
  function automatic logic [RANK_W-1:0] fact_f(input logic [SIZE_W-1:0] i);
    logic [RANK_W-1:0] f;
    unique case (i)
      5'd0:    f = 45'd1;
      5'd1:    f = 45'd1;
      5'd2:    f = 45'd2;
      5'd3:    f = 45'd6;
      5'd4:    f = 45'd24;
      5'd5:    f = 45'd120;
      5'd6:    f = 45'd720;
      5'd7:    f = 45'd5040;
      5'd8:    f = 45'd40320;
      5'd9:    f = 45'd362880;
      5'd10:   f = 45'd3628800;
      5'd11:   f = 45'd39916800;
      5'd12:   f = 45'd479001600;
      5'd13:   f = 45'd6227020800;
      5'd14:   f = 45'd87178291200;
      5'd15:   f = 45'd1307674368000;
      5'd16:   f = 45'd20922789888000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/plu_cell.sv
// plu_cell: one position of the bump chain; holds the working value and a
// copy of an original digit that moves one cell to the right per step.
// Depends on plu_pkg.
module plu_cell
  import plu_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] load_digit,
  input  logic [VAL_W-1:0] in_orig,
  input  logic             in_valid,
  output logic [VAL_W-1:0] out_orig,
  output logic             out_valid,
  output logic [VAL_W-1:0] value
);

  logic [VAL_W-1:0] work;
  logic [VAL_W-1:0] orig;
  logic             orig_valid;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work       <= load_digit;
      orig       <= load_digit;
      orig_valid <= 1'b1;
    end else if (ctrl.step) begin
      // an earlier digit not above the current value pushes it up by one
      if (in_valid && (in_orig <= work)) begin
        work <= work + VAL_W'(1);
      end
      orig       <= in_orig;
      orig_valid <= in_valid;
    end
  end

  assign out_orig  = orig;
  assign out_valid = orig_valid;
  assign value     = work;

endmodule

// File: rtl/plu_chain.sv
// plu_chain: row of plu_cell instances, digit load by index and read-out mux.
// Depends on plu_pkg and plu_cell.
module plu_chain
  import plu_pkg::*;
#(
  parameter int CELLS = RESULT_LIMIT,
  parameter int IDX_W = $clog2(CELLS)
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] load_idx,
  input  logic [VAL_W-1:0] load_digit,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [VAL_W-1:0] rd_value
);

  logic [VAL_W-1:0] orig_w  [CELLS];
  logic             valid_w [CELLS];
  logic [VAL_W-1:0] value_w [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cell_ctrl_t       cc;
    logic [VAL_W-1:0] left_orig;
    logic             left_valid;

    assign cc.load = ctrl.load && (load_idx == IDX_W'(i));
    assign cc.step = ctrl.step;

    if (i == 0) begin : g_head
      assign left_orig  = '0;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_orig  = orig_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    plu_cell u_cell (
      .clk        (clk),
      .ctrl       (cc),
      .load_digit (load_digit),
      .in_orig    (left_orig),
      .in_valid   (left_valid),
      .out_orig   (orig_w[i]),
      .out_valid  (valid_w[i]),
      .value      (value_w[i])
    );
  end

  assign rd_value = value_w[rd_idx];

endmodule

// File: rtl/permutation_unrank_lehmer.sv
// permutation_unrank_lehmer: rank in, permutation elements out in position order.
// sequence for size n: digit extraction resolves 4*n quotient bits (one quotient bit per cycle
// in a shared 48-bit compare-subtract), then n-1 bump steps run in the cell
// chain, then n output transfers follow; one rank at a time.
// reset (synchronous, rst high): idle, no pending output, perm_size back to 16.
// Depends on plu_pkg, plu_chain, plu_cell.
module permutation_unrank_lehmer
  import plu_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [44:0] perm_index, rest zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] element_value, [7:4] position
  output logic        m_tlast,   // last_element
  output logic        m_tuser,   // [0] rank_too_large
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // chain length: never more cells than the result limit
  localparam int CELLS = (MAX_ELEMENTS < RESULT_LIMIT) ? MAX_ELEMENTS : RESULT_LIMIT;
  localparam int IDX_W = $clog2(CELLS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_BUMP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic REG_PERM_SIZE = 1'b0;  // word index of perm_size

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] perm_size;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= SIZE_W'(RESULT_LIMIT);
    end else if (cfg_wr && (paddr[2] == REG_PERM_SIZE)) begin
      perm_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PERM_SIZE) ? {{(32-SIZE_W){1'b0}}, perm_size} : '0;

  // effective size: zero reads as one, anything above the chain length clamps
  logic [SIZE_W-1:0] size_eff;

  always_comb begin
    priority if (perm_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (perm_size > SIZE_W'(CELLS)) begin
      size_eff = SIZE_W'(CELLS);
    end else begin
      size_eff = perm_size;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and digit extraction
  // ---------------------------------------------------------------------------
  logic [1:0]        state;
  logic [RANK_W-1:0] rank;       // running remainder
  logic              too_large;
  logic [IDX_W-1:0]  last_idx;   // n-1
  logic [IDX_W-1:0]  cnt;        // digit index, bump step or output position
  logic [1:0]        bit_cnt;    // quotient bit being resolved
  logic [QBITS-1:0]  quot;

  logic              in_xfer;
  logic [RANK_W-1:0] in_rank;
  logic [RANK_W-1:0] size_fact;
  logic              in_over;

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign in_rank   = s_tdata[RANK_W-1:0];
  assign size_fact = fact_f(size_eff);
  assign in_over   = (in_rank >= size_fact);

  // one restoring-division bit per cycle against (n-1-k)! shifted up
  logic [RANK_W-1:0] digit_fact;
  logic [DIV_W-1:0]  trial;
  logic              q_bit;
  logic [QBITS-1:0]  quot_next;

  assign digit_fact = fact_f(SIZE_W'(last_idx) - SIZE_W'(cnt));
  assign trial      = {{(QBITS-1){1'b0}}, digit_fact} << bit_cnt;
  assign q_bit      = ({{(QBITS-1){1'b0}}, rank} >= trial);
  assign quot_next  = {quot[QBITS-2:0], q_bit};

  cell_ctrl_t       chain_ctrl;
  logic [VAL_W-1:0] rd_value;
  logic             out_free;

  assign chain_ctrl.load = (state == ST_DIV) && (bit_cnt == '0);
  assign chain_ctrl.step = (state == ST_BUMP);
  assign out_free        = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drained output register; while emitting, the emit arm sets it instead
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            // a rank past n!-1 saturates to the last permutation
            rank      <= in_over ? (size_fact - RANK_W'(1)) : in_rank;
            too_large <= in_over;
            last_idx  <= IDX_W'(size_eff - SIZE_W'(1));
            cnt       <= '0;
            bit_cnt   <= 2'(QBITS - 1);
            quot      <= '0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (q_bit) begin
            rank <= rank - trial[RANK_W-1:0];
          end
          bit_cnt <= bit_cnt - 2'd1;
          if (bit_cnt == '0) begin
            // digit done, it went into cell cnt this cycle
            quot <= '0;
            if (cnt == last_idx) begin
              cnt   <= '0;
              state <= (last_idx == '0) ? ST_EMIT : ST_BUMP;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end else begin
            quot <= quot_next;
          end
        end
        ST_BUMP: begin
          // n-1 steps carry every earlier digit past every later cell
          if (cnt == last_idx - IDX_W'(1)) begin
            cnt   <= '0;
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            m_tdata[3:0] <= rd_value;
            m_tdata[7:4] <= VAL_W'(cnt);
            m_tlast      <= (cnt == last_idx);
            m_tuser      <= too_large;
            if (cnt == last_idx) begin
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // cell chain: digits load by index, bump steps shift originals rightward
  // ---------------------------------------------------------------------------
  plu_chain #(
    .CELLS (CELLS),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .ctrl       (chain_ctrl),
    .load_idx   (cnt),
    .load_digit (quot_next),
    .rd_idx     (cnt),
    .rd_value   (rd_value)
  );

endmodule

// File: bench/plu_checker.sv
// plu_checker: watches the rank, element and config channels of
// permutation_unrank_lehmer, predicts every element and compares in order.
// Depends on plu_pkg for widths and the result limit.
module plu_checker
  import plu_pkg::*;
#(
  parameter logic [2:0] SIZE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // [44:0] perm_index, rest zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [3:0] element_value, [7:4] position
  input  logic        m_tlast,   // last_element
  input  logic        m_tuser,   // [0] rank_too_large
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          in_flight
);

  localparam logic [SIZE_W-1:0] SIZE_AT_RESET = 5'd16;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] pos;
    logic             last;
    logic             too_large;
  } element_t;

  element_t          expected_elems[$];
  logic [SIZE_W-1:0] size_reg = SIZE_AT_RESET;
  int                err_total = 0;

  function automatic int active_len(input logic [SIZE_W-1:0] sz);
    int len;
    len = int'(sz);
    if (len < 1) len = 1;
    if (len > MAX_ELEMENTS_DEF) len = MAX_ELEMENTS_DEF;
    if (len > RESULT_LIMIT) len = RESULT_LIMIT;
    return len;
  endfunction

  // lexicographic unranking: each factorial digit picks the digit-th unused value
  task automatic predict_perm(input logic [RANK_W-1:0] rank_in);
    longint unsigned   rem;
    longint unsigned   fct;
    longint unsigned   span;
    int                n;
    int                digit;
    int                v;
    int                k;
    logic [15:0]       taken;
    logic              over;
    element_t          e;
    n = active_len(size_reg);
    span = 1;
    for (k = 2; k <= n; k++) span *= k;
    rem = 64'(rank_in);
    over = (rem >= span);
    // out-of-range rank saturates to the last permutation
    if (over) rem = span - 1;
    taken = '0;
    for (k = 0; k < n; k++) begin
      fct = 1;
      for (v = 2; v <= n - 1 - k; v++) fct *= v;
      digit = int'(rem / fct);
      rem = rem % fct;
      v = 0;
      while (taken[v] || digit > 0) begin
        if (!taken[v]) digit--;
        v++;
      end
      taken[v] = 1'b1;
      e.value = VAL_W'(v);
      e.pos = VAL_W'(k);
      e.last = (k == n - 1);
      e.too_large = over;
      expected_elems.push_back(e);
    end
  endtask

  task automatic check_field(input string what, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    element_t want;
    if (rst) begin
      size_reg = SIZE_AT_RESET;
      expected_elems.delete();
      in_flight <= 0;
      mismatches <= err_total;
    end else begin
      // config transfers: track writes, check reads against the tracked copy
      if (psel && penable && pready && paddr == SIZE_ADDR) begin
        if (pwrite) begin
          size_reg = pwdata[SIZE_W-1:0];
        end else if (prdata !== 32'(size_reg)) begin
          $display("%0t: perm_size read mismatch, expected %0d, got %0d",
                   $time, size_reg, prdata);
          err_total++;
        end
      end
      if (s_tvalid && s_tready) predict_perm(s_tdata[RANK_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (expected_elems.size() == 0) begin
          $display("%0t: element transfer with none expected, got data %h last %b user %b",
                   $time, m_tdata, m_tlast, m_tuser);
          err_total++;
        end else begin
          want = expected_elems.pop_front();
          check_field("element_value", want.value, m_tdata[3:0]);
          check_field("position", want.pos, m_tdata[7:4]);
          check_field("last_element", {3'b000, want.last}, {3'b000, m_tlast});
          check_field("rank_too_large", {3'b000, want.too_large}, {3'b000, m_tuser});
        end
      end
      in_flight <= expected_elems.size();
      mismatches <= err_total;
    end
  end

endmodule

// File: bench/permutation_unrank_lehmer_test.sv
// permutation_unrank_lehmer_test: drives ranks and perm_size settings into the
// unranking block with random gaps and back-pressure; plu_checker predicts and compares.
// Depends on plu_pkg, permutation_unrank_lehmer and plu_checker.
module permutation_unrank_lehmer_test
  import plu_pkg::*;
();

  localparam logic [2:0] PERM_SIZE_ADDR = 3'd0;  // register 0 at byte address 0
  localparam int CYCLE_LIMIT  = 500000;          // far above the slowest correct run
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [44:0] perm_index, rest zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] element_value, [7:4] position
  logic        m_tlast;        // last_element
  logic        m_tuser;        // [0] rank_too_large
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int in_flight;
  int cycle_count = 0;
  int ranks_sent = 0;
  int stall_left = 0;
  int calm_left = 0;
  int ready_roll;

  permutation_unrank_lehmer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  plu_checker #(.SIZE_ADDR(PERM_SIZE_ADDR)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // element-side back-pressure: short stalls mostly, a few long ones,
  // and now and then a long stretch with none
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (calm_left > 0) begin
      m_tready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 20) stall_left <= $urandom_range(1, 3);
      else if (ready_roll < 23) stall_left <= $urandom_range(10, 40);
      else if (ready_roll < 25) calm_left <= $urandom_range(50, 200);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_rank(input logic [RANK_W-1:0] rank);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, rank};
    do @(posedge clk); while (!s_tready);
    ranks_sent++;
  endtask

  // hold off new ranks until every predicted element has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (8) @(posedge clk);
  endtask

  // a setup phase and an access phase, then psel and penable drop back to idle
  task automatic apb_access(input logic is_write, input logic [31:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= PERM_SIZE_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int size);
    apb_access(1'b1, 32'(size));
    apb_access(1'b0, '0);
  endtask

  function automatic int active_size(input int size);
    if (size < 1) return 1;
    if (size > RESULT_LIMIT) return RESULT_LIMIT;
    return size;
  endfunction

  function automatic logic [RANK_W-1:0] full_rank();
    return {13'($urandom_range(0, 8191)), $urandom()};
  endfunction

  // mostly in range, some at the boundary, some anywhere in 45 bits
  function automatic logic [RANK_W-1:0] pick_rank(input int n);
    logic [RANK_W-1:0] span;
    int r;
    span = fact_f(SIZE_W'(n));
    r = $urandom_range(0, 9);
    if (r < 7) return full_rank() % span;
    else if (r == 7) return span - RANK_W'(1);
    else if (r == 8) return span;
    else return full_rank();
  endfunction

  initial begin
    int size;
    int n;
    int batch;
    int random_goal;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 16: read back, extremes, alternating bit patterns, too-large ranks
    apb_access(1'b0, '0);
    send_rank('0);
    send_rank(45'd1);
    send_rank(fact_f(5'd16) - 45'd1);
    send_rank(fact_f(5'd16));
    send_rank('1);
    send_rank({15{3'b101}});
    send_rank({15{3'b010}});
    send_rank(fact_f(5'd15));
    send_rank(fact_f(5'd15) - 45'd1);
    wait_drained();

    // single element, including an out-of-range rank
    set_size(1);
    send_rank('0);
    send_rank(45'd1);
    send_rank('1);
    wait_drained();

    // size zero behaves as one
    set_size(0);
    send_rank('0);
    send_rank(45'd3);
    wait_drained();

    // sizes above the limit clamp to 16
    set_size(31);
    send_rank(fact_f(5'd16) - 45'd1);
    send_rank(fact_f(5'd16));
    wait_drained();

    set_size(2);
    send_rank('0);
    send_rank(45'd1);
    send_rank(45'd2);
    wait_drained();

    set_size(17);
    send_rank(45'd12345);
    wait_drained();

    // random phases: new size, then a batch of ranks
    random_goal = ranks_sent + RANDOM_ITEMS;
    while (ranks_sent < random_goal) begin
      batch = $urandom_range(0, 19);
      if (batch == 0) size = 0;
      else if (batch < 3) size = $urandom_range(17, 31);
      else if (batch < 6) size = 16;
      else size = $urandom_range(1, 15);
      n = active_size(size);
      set_size(size);
      batch = $urandom_range(4, 12);
      repeat (batch) begin
        if ($urandom_range(0, 7) == 0) wait_drained();
        send_rank(pick_rank(n));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
